[src/tsc_pkg.sv]
// Shared constants and types for the timer prescaler and count selection block.
// Holds the clock source table, field widths, status codes and stage structs.
// Depends on nothing.
package tsc_pkg;

	// Field and internal widths
	localparam int REQ_W    = 32;
	localparam int CNT_W    = 16;
	localparam int ACH_W    = 32;
	localparam int STATUS_W = 2;
	localparam int SEL_W    = 3;
	localparam int NSRC     = 5;
	localparam int SRC_IDX_W = $clog2(NSRC);

	// Quotient estimate width: numerator below 2**32 divided by at least 1000
	localparam int QUO_W    = 23;
	// Remainder width: below the largest divisor, 3600000
	localparam int REM_W    = 22;
	// Width of the reciprocal product
	localparam int PROD_W   = REQ_W + QUO_W;
	// Width of count times divisor in the achieved interval
	localparam int ACHP_W   = CNT_W + REQ_W;

	// Reset value of the minimum count register
	localparam logic [CNT_W-1:0] MIN_COUNT_RESET = 16'd16;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_STOP   = 2'd0,
		STATUS_SET    = 2'd1,
		STATUS_NO_FIT = 2'd2
	} status_t;

	// Clock select codes
	localparam logic [SEL_W-1:0] SEL_TICK_4096 = 3'd0;
	localparam logic [SEL_W-1:0] SEL_TICK_64   = 3'd1;
	localparam logic [SEL_W-1:0] SEL_SECOND    = 3'd2;
	localparam logic [SEL_W-1:0] SEL_MINUTE    = 3'd3;
	localparam logic [SEL_W-1:0] SEL_HOUR      = 3'd4;

	// Sources in order of trial: 1/64 s, 1 s, 1 min, 1 h, 1/4096 s
	localparam int SRC_64 = 0;

	// Milliseconds per unit (the divisor)
	localparam logic [REQ_W-1:0] SRC_DIV [NSRC] = '{
		32'd1000, 32'd1000, 32'd60000, 32'd3600000, 32'd1000
	};
	// floor(2**32 / divisor)
	localparam logic [QUO_W-1:0] SRC_RECIP [NSRC] = '{
		23'd4294967, 23'd4294967, 23'd71582, 23'd1193, 23'd4294967
	};
	// log2 of ticks per unit
	localparam logic [3:0] SRC_SHIFT [NSRC] = '{
		4'd6, 4'd0, 4'd0, 4'd0, 4'd12
	};
	// Half a unit in ticks, for rounding the achieved interval
	localparam logic [REQ_W-1:0] SRC_HALF [NSRC] = '{
		32'd32, 32'd0, 32'd0, 32'd0, 32'd2048
	};
	// Largest request in ms that the source can time
	localparam logic [REQ_W-1:0] SRC_LIMIT [NSRC] = '{
		32'd1023984, 32'd65535000, 32'd3932100000, 32'hFFFF_FFFF, 32'd15999
	};
	// Largest count of the source
	localparam logic [CNT_W-1:0] SRC_TOP [NSRC] = '{
		16'd65535, 16'd65535, 16'd65535, 16'd1193, 16'd65535
	};
	// Largest count times divisor
	localparam logic [REQ_W-1:0] SRC_TOP_PROD [NSRC] = '{
		32'd65535000, 32'd65535000, 32'd3932100000, 32'd4294800000, 32'd65535000
	};
	// Select code of each source
	localparam logic [SEL_W-1:0] SRC_CODE [NSRC] = '{
		SEL_TICK_64, SEL_SECOND, SEL_MINUTE, SEL_HOUR, SEL_TICK_4096
	};

	// Quotient stage contents
	typedef struct packed {
		logic [REQ_W-1:0]            req;
		logic [NSRC-1:0][QUO_W-1:0]  quo;
	} quot_t;

	// Evaluation stage contents
	typedef struct packed {
		logic [NSRC-1:0]             acc;
		logic [NSRC-1:0][CNT_W-1:0]  cnt;
	} eval_t;

	// Scaled request: request times ticks per unit
	function automatic logic [REQ_W-1:0] src_num(
		input logic [REQ_W-1:0] req,
		input int               idx
	);
		return req << SRC_SHIFT[idx];
	endfunction

endpackage

[src/tsc_quot_stage.sv]
// Quotient estimate stage: scaled request times reciprocal for each source.
// Uses tsc_pkg; registers the estimates for the evaluation stage.
module tsc_quot_stage (
	input  logic                    clk,
	input  logic                    en,
	input  logic [tsc_pkg::REQ_W-1:0] req_s1,
	output tsc_pkg::quot_t          quot_s2
);

	tsc_pkg::quot_t quot_d;

	// Estimate each quotient; it is the true one or one short
	always_comb begin
		logic [tsc_pkg::PROD_W-1:0] prod;
		quot_d.req = req_s1;
		quot_d.quo = '0;
		for (int i = 0; i < tsc_pkg::NSRC; i++) begin
			prod = tsc_pkg::PROD_W'(tsc_pkg::src_num(req_s1, i))
				* tsc_pkg::PROD_W'(tsc_pkg::SRC_RECIP[i]);
			quot_d.quo[i] = prod[tsc_pkg::PROD_W-1 -: tsc_pkg::QUO_W];
		end
	end

	// Hold on stall, advance otherwise
	always_ff @(posedge clk) begin
		if (en) begin
			quot_s2 <= quot_d;
		end
	end

endmodule

[src/tsc_eval_stage.sv]
// Evaluation stage: remainder, rounding, saturation and acceptance per source.
// Uses tsc_pkg; takes the quotient stage and the minimum count register.
module tsc_eval_stage (
	input  logic                      clk,
	input  logic                      en,
	input  tsc_pkg::quot_t            quot_s2,
	input  logic [tsc_pkg::CNT_W-1:0] minimum_count,
	output tsc_pkg::eval_t            eval_s3
);

	tsc_pkg::eval_t eval_d;

	// Work out the count and the acceptance of every source side by side
	always_comb begin
		logic [tsc_pkg::REQ_W-1:0] num;
		logic [tsc_pkg::REQ_W-1:0] rem_raw;
		logic [tsc_pkg::REM_W-1:0] rem;
		logic [tsc_pkg::QUO_W-1:0] quo;
		logic [tsc_pkg::QUO_W:0]   cnt_up;
		logic [tsc_pkg::REQ_W-1:0] err;
		logic [tsc_pkg::CNT_W-1:0] cnt;
		logic                      over;
		logic                      up;
		logic                      skip;
		eval_d = '0;
		// Any earlier source skipped is the same as the first one skipped
		over = quot_s2.req > tsc_pkg::SRC_LIMIT[tsc_pkg::SRC_64];
		for (int i = 0; i < tsc_pkg::NSRC; i++) begin
			num = tsc_pkg::src_num(quot_s2.req, i);
			rem_raw = num - tsc_pkg::REQ_W'(quot_s2.quo[i] * tsc_pkg::SRC_DIV[i]);
			// Correct an estimate that is one short
			if (rem_raw >= tsc_pkg::SRC_DIV[i]) begin
				quo = quot_s2.quo[i] + 1'b1;
				rem = tsc_pkg::REM_W'(rem_raw - tsc_pkg::SRC_DIV[i]);
			end else begin
				quo = quot_s2.quo[i];
				rem = tsc_pkg::REM_W'(rem_raw);
			end
			// Round to nearest, or up once a source has been skipped
			if (over) begin
				up = rem != '0;
			end else begin
				up = tsc_pkg::REQ_W'({rem, 1'b0}) >= tsc_pkg::SRC_DIV[i];
			end
			cnt_up = {1'b0, quo} + (tsc_pkg::QUO_W+1)'(up);
			err = up ? tsc_pkg::SRC_DIV[i] - tsc_pkg::REQ_W'(rem) : tsc_pkg::REQ_W'(rem);
			// Saturate at the top count
			if (cnt_up > (tsc_pkg::QUO_W+1)'(tsc_pkg::SRC_TOP[i])) begin
				cnt = tsc_pkg::SRC_TOP[i];
				err = num - tsc_pkg::SRC_TOP_PROD[i];
			end else begin
				cnt = cnt_up[tsc_pkg::CNT_W-1:0];
			end
			skip = quot_s2.req > tsc_pkg::SRC_LIMIT[i];
			// The last source needs only to fit
			eval_d.acc[i] = !skip && ((i == tsc_pkg::NSRC - 1) ||
				(cnt >= minimum_count && {err, 8'b0} <= {8'b0, num}));
			eval_d.cnt[i] = cnt;
		end
	end

	// Hold on stall, advance otherwise
	always_ff @(posedge clk) begin
		if (en) begin
			eval_s3 <= eval_d;
		end
	end

endmodule

[src/tsc_pick_stage.sv]
// Result stage: picks the first accepted source and forms the achieved interval.
// Uses tsc_pkg; drives the result register of the block.
module tsc_pick_stage (
	input  logic                      clk,
	input  logic                      en,
	input  tsc_pkg::eval_t            eval_s3,
	output tsc_pkg::status_t          status_q,
	output logic [tsc_pkg::SEL_W-1:0] clock_select_q,
	output logic [tsc_pkg::CNT_W-1:0] count_value_q,
	output logic [tsc_pkg::ACH_W-1:0] achieved_ms_q
);

	logic                          found;
	logic [tsc_pkg::SRC_IDX_W-1:0] pick;
	logic [tsc_pkg::CNT_W-1:0]     cnt_sel;
	logic [tsc_pkg::ACHP_W-1:0]    ach_sum;
	logic [tsc_pkg::ACH_W-1:0]     ach;
	tsc_pkg::status_t              status_d;
	logic [tsc_pkg::SEL_W-1:0]     sel_d;
	logic [tsc_pkg::CNT_W-1:0]     cnt_d;
	logic [tsc_pkg::ACH_W-1:0]     ach_d;

	// Find the first accepted source in order of trial
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int i = tsc_pkg::NSRC - 1; i >= 0; i--) begin
			if (eval_s3.acc[i]) begin
				found = 1'b1;
				pick  = tsc_pkg::SRC_IDX_W'(i);
			end
		end
	end

	// Achieved interval: count times unit, rounded to whole ms, at least 1
	assign cnt_sel = eval_s3.cnt[pick];
	assign ach_sum = tsc_pkg::ACHP_W'(cnt_sel) * tsc_pkg::ACHP_W'(tsc_pkg::SRC_DIV[pick])
		+ tsc_pkg::ACHP_W'(tsc_pkg::SRC_HALF[pick]);
	assign ach = tsc_pkg::ACH_W'(ach_sum >> tsc_pkg::SRC_SHIFT[pick]);

	// A zero request ends here with a zero count, so it reads as stop
	always_comb begin
		status_d = tsc_pkg::STATUS_STOP;
		sel_d    = '0;
		cnt_d    = '0;
		ach_d    = '0;
		if (!found) begin
			status_d = tsc_pkg::STATUS_NO_FIT;
		end else if (cnt_sel != '0) begin
			status_d = tsc_pkg::STATUS_SET;
			sel_d    = tsc_pkg::SRC_CODE[pick];
			cnt_d    = cnt_sel;
			ach_d    = (ach != '0) ? ach : tsc_pkg::ACH_W'(1);
		end
	end

	// Hold the result while it is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			status_q       <= status_d;
			clock_select_q <= sel_d;
			count_value_q  <= cnt_d;
			achieved_ms_q  <= ach_d;
		end
	end

endmodule

[src/timer_prescaler_count_select.sv]
// Timer prescaler and count selection, top level.
// An input transfer passes the input, quotient, evaluation and result registers
// before its result shows valid. Throughput: one item per cycle unless stalled,
// through all four; a stalled result holds while empty stages fill behind it.
// Reset clears all valid flags and sets the minimum count to 16.
// Uses tsc_pkg, tsc_quot_stage, tsc_eval_stage and tsc_pick_stage.
module timer_prescaler_count_select (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [tsc_pkg::REQ_W-1:0] request_ms,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [tsc_pkg::STATUS_W-1:0] status,
	output logic [tsc_pkg::SEL_W-1:0] clock_select,
	output logic [tsc_pkg::CNT_W-1:0] count_value,
	output logic [tsc_pkg::ACH_W-1:0] achieved_ms,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [tsc_pkg::CNT_W-1:0] minimum_count
);

	logic                      v_s1;
	logic                      v_s2;
	logic                      v_s3;
	logic                      out_valid_q;
	logic                      en_s1;
	logic                      en_s2;
	logic                      en_s3;
	logic                      en_out;
	logic [tsc_pkg::REQ_W-1:0] req_s1;
	logic [tsc_pkg::CNT_W-1:0] minimum_count_q;
	tsc_pkg::quot_t            quot_s2;
	tsc_pkg::eval_t            eval_s3;
	tsc_pkg::status_t          status_q;

	// A stage advances when it is empty or the one after it advances
	assign en_out   = !out_valid_q || !out_stall;
	assign en_s3    = !v_s3 || en_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	// Valid flags of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (en_s1) begin
			req_s1 <= request_ms;
		end
	end

	// Configuration: always ready, take the write on a transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minimum_count_q <= tsc_pkg::MIN_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			minimum_count_q <= minimum_count;
		end
	end

	tsc_quot_stage u_quot (
		.clk     (clk),
		.en      (en_s2),
		.req_s1  (req_s1),
		.quot_s2 (quot_s2)
	);

	tsc_eval_stage u_eval (
		.clk           (clk),
		.en            (en_s3),
		.quot_s2       (quot_s2),
		.minimum_count (minimum_count_q),
		.eval_s3       (eval_s3)
	);

	tsc_pick_stage u_pick (
		.clk            (clk),
		.en             (en_out),
		.eval_s3        (eval_s3),
		.status_q       (status_q),
		.clock_select_q (clock_select),
		.count_value_q  (count_value),
		.achieved_ms_q  (achieved_ms)
	);

	assign out_valid = out_valid_q;
	assign status    = status_q;

	// Input stalls only when every stage is full and the result is held
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

	// A waiting item in the last stage moves into a free result register
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en_out) |=> out_valid)
		else $error("evaluated item lost on its way to the result");

	// A set timer carries a nonzero count and interval
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_q == tsc_pkg::STATUS_SET) |->
			(count_value != '0 && achieved_ms != '0))
		else $error("timer set with zero count or interval");

	// Anything but a set timer carries zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status_q != tsc_pkg::STATUS_SET) |->
			(count_value == '0 && achieved_ms == '0 && clock_select == '0))
		else $error("nonzero fields without a set timer");

endmodule
